>>> rtl/core/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg: shared types for the threshold crossing histogram
// Function codes of an input beat and the request passed to the update stage.
// ----------------------------------------------------------------------------
package tch_pkg;

	// function codes carried on an input beat
	typedef enum logic [1:0] {
		FUNC_SAMPLE     = 2'd0,
		FUNC_READ       = 2'd1,
		FUNC_READ_CLEAR = 2'd2,
		FUNC_NONE       = 2'd3
	} func_t;

	// operation on one bin of the count memory
	typedef enum logic [2:0] {
		OP_INC   = 3'b001,
		OP_READ  = 3'b010,
		OP_CLEAR = 3'b100
	} op_t;

	// request travelling from the front end to the update stage
	typedef struct packed {
		logic valid;
		op_t  op;
		logic in_range;
	} req_t;

endpackage

>>> rtl/core/tch_count_ram.sv
// ----------------------------------------------------------------------------
// tch_count_ram: bin count memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tch_count_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and registered read (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/tch_front.sv
// ----------------------------------------------------------------------------
// tch_front: sample tracking and request decode
// Keeps the previous sample and the waveform position, detects rising
// crossings and issues the memory read for the bin that the beat touches.
// ----------------------------------------------------------------------------
module tch_front import tch_pkg::*; #(
	parameter int BINS        = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          adv,
	input  logic [1:0]                    func,
	input  logic signed [SAMPLE_BITS-1:0] intensity,
	input  logic                          first_sample,
	input  logic [$clog2(BINS)-1:0]       read_bin,
	input  logic signed [SAMPLE_BITS-1:0] threshold,
	output logic                          rd_en,
	output logic [$clog2(BINS)-1:0]       rd_addr,
	output req_t                          req_s1,
	output logic [$clog2(BINS)-1:0]       addr_s1
);

	localparam int BIN_BITS = $clog2(BINS);
	localparam int POS_BITS = $clog2(BINS + 1);

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic [POS_BITS-1:0]           pos_q;
	logic [POS_BITS-1:0]           pos_next;
	logic                          hit;
	logic                          rd_ok;
	func_t                         f;
	req_t                          req_d;
	logic [BIN_BITS-1:0]           addr_d;

	// position of this sample, crossing test
	always_comb begin
		pos_next = pos_q;
		if (pos_q < POS_BITS'(BINS)) begin
			pos_next = pos_q + POS_BITS'(1);
		end
		hit = !first_sample && (pos_next < POS_BITS'(BINS)) &&
			(prev_q < threshold) && (threshold < intensity);
		rd_ok = {1'b0, read_bin} < (BIN_BITS + 1)'(BINS);
	end

	// decode the beat into a bin request
	always_comb begin
		f      = func_t'(func);
		req_d  = '0;
		addr_d = read_bin;
		case (f)
			FUNC_SAMPLE: begin
				req_d.valid    = hit;
				req_d.op       = OP_INC;
				req_d.in_range = 1'b1;
				addr_d         = pos_next[BIN_BITS-1:0];
			end
			FUNC_READ: begin
				req_d.valid    = 1'b1;
				req_d.op       = OP_READ;
				req_d.in_range = rd_ok;
			end
			FUNC_READ_CLEAR: begin
				req_d.valid    = 1'b1;
				req_d.op       = OP_CLEAR;
				req_d.in_range = rd_ok;
			end
			default: begin
				req_d = '0;
			end
		endcase
	end

	assign rd_en   = accept && req_d.valid && req_d.in_range;
	assign rd_addr = addr_d;

	// waveform state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pos_q  <= '0;
		end else if (accept && (f == FUNC_SAMPLE)) begin
			prev_q <= intensity;
			pos_q  <= first_sample ? '0 : pos_next;
		end
	end

	// stage 1 request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else if (accept) begin
			req_s1 <= req_d;
		end else if (adv) begin
			req_s1.valid <= 1'b0;
		end
	end

	// stage 1 address
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= addr_d;
		end
	end

endmodule

>>> rtl/core/tch_update.sv
// ----------------------------------------------------------------------------
// tch_update: read-modify-write of one bin and result register
// Forwards the last written count over the memory read, saturates the
// increment and holds the read result until the output side takes it.
// ----------------------------------------------------------------------------
module tch_update import tch_pkg::*; #(
	parameter int BINS       = 4096,
	parameter int COUNT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  req_t                       req_s1,
	input  logic [$clog2(BINS)-1:0]    addr_s1,
	input  logic [COUNT_BITS-1:0]      rdata,
	input  logic                       out_ready,
	output logic                       adv,
	output logic                       we,
	output logic [$clog2(BINS)-1:0]    waddr,
	output logic [COUNT_BITS-1:0]      wdata,
	output logic                       out_valid,
	output logic [$clog2(BINS)-1:0]    bin_index,
	output logic [COUNT_BITS-1:0]      bin_count,
	output logic                       nonzero
);

	localparam int BIN_BITS = $clog2(BINS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic                  fwd_valid_q;
	logic [BIN_BITS-1:0]   fwd_addr_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  is_read;
	logic                  out_free;
	logic                  out_valid_q;

	// current count, with the last write forwarded
	always_comb begin
		cur = rdata;
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			cur = fwd_data_q;
		end
		is_read  = req_s1.op != OP_INC;
		out_free = !out_valid_q || out_ready;
		adv      = req_s1.valid && (!is_read || out_free);
		we       = adv && req_s1.in_range && (req_s1.op != OP_READ);
		waddr    = addr_s1;
		wdata    = '0;
		if (req_s1.op == OP_INC) begin
			wdata = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
		end
		cnt_rd = req_s1.in_range ? cur : '0;
	end

	// forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_addr_q <= waddr;
			fwd_data_q <= wdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_read) begin
			bin_index <= addr_s1;
			bin_count <= cnt_rd;
			nonzero   <= cnt_rd != '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/threshold_crossing_histogram_top.sv
// ----------------------------------------------------------------------------
// threshold_crossing_histogram_top: threshold crossing time histogram
// Counts rising threshold crossings per waveform position in a bin memory.
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle unless the sweep runs or the update
// stage stalls: a sample beat reads its bin at accept and writes the
// incremented count in the next cycle, a forwarding register covering
// back-to-back hits on the same bin. A read beat passes stage 1 and then
// the result register, which raises out_valid; stage 1 stalls while a held
// result is not taken. After reset the block sweeps the count memory to
// zero, one bin per cycle, while in_ready stays low; threshold writes are taken throughout.
module threshold_crossing_histogram_top import tch_pkg::*; #(
	parameter int BINS        = 4096,
	parameter int COUNT_BITS  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic signed [SAMPLE_BITS-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic signed [SAMPLE_BITS-1:0] intensity,
	input  logic                          first_sample,
	input  logic [$clog2(BINS)-1:0]       read_bin,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [$clog2(BINS)-1:0]       bin_index,
	output logic [COUNT_BITS-1:0]         bin_count,
	output logic                          nonzero
);

	localparam int BIN_BITS = $clog2(BINS);

	logic signed [SAMPLE_BITS-1:0] threshold_q;
	logic                          clr_q;
	logic [BIN_BITS-1:0]           clr_addr_q;
	logic                          accept;
	logic                          adv;
	logic                          rd_en;
	logic [BIN_BITS-1:0]           rd_addr;
	req_t                          req_s1;
	logic [BIN_BITS-1:0]           addr_s1;
	logic [COUNT_BITS-1:0]         rdata;
	logic                          upd_we;
	logic [BIN_BITS-1:0]           upd_waddr;
	logic [COUNT_BITS-1:0]         upd_wdata;
	logic                          mem_we;
	logic [BIN_BITS-1:0]           mem_waddr;
	logic [COUNT_BITS-1:0]         mem_wdata;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + BIN_BITS'(1);
			if (clr_addr_q == BIN_BITS'(BINS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// input handshake
	assign in_ready = !clr_q && (!req_s1.valid || adv);
	assign accept   = in_valid && in_ready;

	tch_front #(
		.BINS        (BINS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.adv          (adv),
		.func         (func),
		.intensity    (intensity),
		.first_sample (first_sample),
		.read_bin     (read_bin),
		.threshold    (threshold_q),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.req_s1       (req_s1),
		.addr_s1      (addr_s1)
	);

	// write port shared between the sweep and the update stage
	assign mem_we    = clr_q || upd_we;
	assign mem_waddr = clr_q ? clr_addr_q : upd_waddr;
	assign mem_wdata = clr_q ? '0 : upd_wdata;

	tch_count_ram #(
		.DEPTH (BINS),
		.WIDTH (COUNT_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	tch_update #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_s1    (req_s1),
		.addr_s1   (addr_s1),
		.rdata     (rdata),
		.out_ready (out_ready),
		.adv       (adv),
		.we        (upd_we),
		.waddr     (upd_waddr),
		.wdata     (upd_wdata),
		.out_valid (out_valid),
		.bin_index (bin_index),
		.bin_count (bin_count),
		.nonzero   (nonzero)
	);

	// no beat is taken while the sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready)
		else $error("input beat accepted during clearing sweep");

	// a saturating increment never wraps to zero
	a_inc_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_we && (req_s1.op == OP_INC)) |-> (upd_wdata != '0))
		else $error("bin count wrapped on increment");

	// a result appears only after a read request left stage 1
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(adv && (req_s1.op != OP_INC)))
		else $error("result without a read request");

	// the update stage never writes while the sweep owns the port
	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !upd_we)
		else $error("update write during clearing sweep");

endmodule
